/* rtl/gic_pkg.sv */
// Shared types and defaults for the grid index converter.
package gic_pkg;

	localparam int AXIS_BITS_DEF = 10;

	typedef enum logic [1:0] {
		CMD_IJK_TO_CELL = 2'd0,
		CMD_CELL_TO_IJK = 2'd1,
		CMD_IJK_TO_NODE = 2'd2,
		CMD_NODE_TO_IJK = 2'd3
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic rev;
		logic bad;
	} stage_flags_t;

endpackage

/* rtl/gic_apb_regs.sv */
// APB register file holding the cell counts per axis.
module gic_apb_regs #(
	parameter int AXIS_BITS = gic_pkg::AXIS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic [AXIS_BITS-1:0] cells_x,
	output logic [AXIS_BITS-1:0] cells_y,
	output logic [AXIS_BITS-1:0] cells_z
);
	import gic_pkg::*;

	localparam logic [1:0] REG_CELLS_X = 2'd0;
	localparam logic [1:0] REG_CELLS_Y = 2'd1;
	localparam logic [1:0] REG_CELLS_Z = 2'd2;

	logic [AXIS_BITS-1:0] cells_x_q;
	logic [AXIS_BITS-1:0] cells_y_q;
	logic [AXIS_BITS-1:0] cells_z_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= AXIS_BITS'(1);
			cells_y_q <= AXIS_BITS'(1);
			cells_z_q <= AXIS_BITS'(1);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CELLS_X: cells_x_q <= pwdata[AXIS_BITS-1:0];
				REG_CELLS_Y: cells_y_q <= pwdata[AXIS_BITS-1:0];
				REG_CELLS_Z: cells_z_q <= pwdata[AXIS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CELLS_X: prdata = 32'(cells_x_q);
			REG_CELLS_Y: prdata = 32'(cells_y_q);
			REG_CELLS_Z: prdata = 32'(cells_z_q);
			default:     prdata = '0;
		endcase
	end

	assign cells_x = cells_x_q;
	assign cells_y = cells_y_q;
	assign cells_z = cells_z_q;

endmodule

/* rtl/gic_front.sv */
// Front pipeline: axis sizes, range checks, products and forward id (four stages).
module gic_front #(
	parameter int AXIS_BITS = gic_pkg::AXIS_BITS_DEF,
	localparam int NW   = AXIS_BITS + 1,
	localparam int PW   = 2 * NW,
	localparam int ID_W = 3 * AXIS_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [AXIS_BITS-1:0] cells_x,
	input  logic [AXIS_BITS-1:0] cells_y,
	input  logic [AXIS_BITS-1:0] cells_z,
	input  logic                 item_valid,
	input  logic [1:0]           command,
	input  logic [AXIS_BITS-1:0] index_i,
	input  logic [AXIS_BITS-1:0] index_j,
	input  logic [AXIS_BITS-1:0] index_k,
	input  logic [ID_W-1:0]      linear_id,
	output gic_pkg::stage_flags_t flags_s4,
	output logic [ID_W-1:0]      lid_s4,
	output logic [PW-1:0]        plane_s4,
	output logic [ID_W-1:0]      id_s4,
	output logic [NW-1:0]        nx_s4
);
	import gic_pkg::*;

	localparam int JW  = AXIS_BITS + NW;
	localparam int IJW = JW + 1;
	localparam int TW  = PW + NW;
	localparam int KW  = AXIS_BITS + PW;

	cmd_t         cmd;
	logic         nodes;
	logic         rev;
	logic [NW-1:0] nx_c, ny_c, nz_c;
	logic         fwd_bad_c;

	stage_flags_t        flags_s1, flags_s2, flags_s3;
	logic [AXIS_BITS-1:0] ci_s1, cj_s1, ck_s1;
	logic [ID_W-1:0]     lid_s1, lid_s2, lid_s3;
	logic [NW-1:0]       nx_s1, ny_s1, nz_s1;

	logic [PW-1:0]        plane_c;
	logic [JW-1:0]        jnx_c;
	logic [PW-1:0]        plane_s2;
	logic [JW-1:0]        jnx_s2;
	logic [AXIS_BITS-1:0] ci_s2, ck_s2;
	logic [NW-1:0]        nz_s2, nx_s2;

	logic [TW-1:0]  total_c;
	logic [KW-1:0]  kp_c;
	logic [IJW-1:0] ij_c;
	logic [TW-1:0]  total_s3;
	logic [KW-1:0]  kp_s3;
	logic [IJW-1:0] ij_s3;
	logic [PW-1:0]  plane_s3;
	logic [NW-1:0]  nx_s3;

	logic [ID_W-1:0] id_c;
	logic            rev_bad_c;
	stage_flags_t    flags_c4;

	assign cmd = cmd_t'(command);

	always_comb begin
		unique case (cmd)
			CMD_IJK_TO_CELL: begin nodes = 1'b0; rev = 1'b0; end
			CMD_CELL_TO_IJK: begin nodes = 1'b0; rev = 1'b1; end
			CMD_IJK_TO_NODE: begin nodes = 1'b1; rev = 1'b0; end
			CMD_NODE_TO_IJK: begin nodes = 1'b1; rev = 1'b1; end
		endcase
	end

	// stage 1: axis sizes and forward range check
	assign nx_c = NW'(cells_x) + NW'(nodes);
	assign ny_c = NW'(cells_y) + NW'(nodes);
	assign nz_c = NW'(cells_z) + NW'(nodes);
	assign fwd_bad_c = (NW'(index_i) >= nx_c) || (NW'(index_j) >= ny_c) ||
		(NW'(index_k) >= nz_c);

	// stage 2: plane size and j*nx
	assign plane_c = PW'(nx_s1) * PW'(ny_s1);
	assign jnx_c   = JW'(cj_s1) * JW'(nx_s1);

	// stage 3: total count, k*plane, i + j*nx
	assign total_c = TW'(plane_s2) * TW'(nz_s2);
	assign kp_c    = KW'(ck_s2) * KW'(plane_s2);
	assign ij_c    = IJW'(ci_s2) + IJW'(jnx_s2);

	// stage 4: forward id and reverse range check
	assign id_c      = ID_W'(ij_s3) + ID_W'(kp_s3);
	assign rev_bad_c = TW'(lid_s3) >= total_s3;

	always_comb begin
		flags_c4     = flags_s3;
		flags_c4.bad = flags_s3.rev ? rev_bad_c : flags_s3.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
			flags_s3 <= '0;
			flags_s4 <= '0;
		end else if (en) begin
			flags_s1 <= '{valid: item_valid, rev: rev, bad: fwd_bad_c};
			flags_s2 <= flags_s1;
			flags_s3 <= flags_s2;
			flags_s4 <= flags_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ci_s1    <= index_i;
			cj_s1    <= index_j;
			ck_s1    <= index_k;
			lid_s1   <= linear_id;
			nx_s1    <= nx_c;
			ny_s1    <= ny_c;
			nz_s1    <= nz_c;

			plane_s2 <= plane_c;
			jnx_s2   <= jnx_c;
			ci_s2    <= ci_s1;
			ck_s2    <= ck_s1;
			lid_s2   <= lid_s1;
			nz_s2    <= nz_s1;
			nx_s2    <= nx_s1;

			total_s3 <= total_c;
			kp_s3    <= kp_c;
			ij_s3    <= ij_c;
			lid_s3   <= lid_s2;
			plane_s3 <= plane_s2;
			nx_s3    <= nx_s2;

			lid_s4   <= lid_s3;
			plane_s4 <= plane_s3;
			id_s4    <= id_c;
			nx_s4    <= nx_s3;
		end
	end

endmodule

/* rtl/gic_div_step.sv */
// One registered restoring-division step, producing one quotient bit.
module gic_div_step #(
	parameter int AXIS_BITS = gic_pkg::AXIS_BITS_DEF,
	parameter int SHIFT     = 0,
	parameter int SIDE_W    = 1,
	localparam int W        = 3 * AXIS_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  gic_pkg::stage_flags_t flags,
	input  logic [W-1:0]          rem,
	input  logic [W-1:0]          div,
	input  logic [AXIS_BITS-1:0]  quo,
	input  logic [SIDE_W-1:0]     side,
	output gic_pkg::stage_flags_t flags_s1,
	output logic [W-1:0]          rem_s1,
	output logic [W-1:0]          div_s1,
	output logic [AXIS_BITS-1:0]  quo_s1,
	output logic [SIDE_W-1:0]     side_s1
);
	import gic_pkg::*;

	logic [W-1:0]         d_sh;
	logic                 ge;
	logic [W-1:0]         rem_c;
	logic [AXIS_BITS-1:0] quo_c;

	assign d_sh  = div << SHIFT;
	assign ge    = rem >= d_sh;
	assign rem_c = ge ? (rem - d_sh) : rem;

	always_comb begin
		quo_c        = quo;
		quo_c[SHIFT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else if (en) begin
			flags_s1 <= flags;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_c;
			div_s1  <= div;
			quo_s1  <= quo_c;
			side_s1 <= side;
		end
	end

endmodule

/* rtl/grid_index_converter_unit.sv */
// Pipeline: one restoring divider stage per quotient bit for k, then j.
// Throughput: one item per cycle while the output skid is empty.
// A one-entry output skid takes the result that meets a stall; input and pipeline then hold.
// Reset clears all stage valid bits and the skid; cell counts reset to 1.
// Top level: 3-D grid index converter, APB config, stream in and out.
module grid_index_converter_unit #(
	parameter int AXIS_BITS = gic_pkg::AXIS_BITS_DEF,
	localparam int ID_W       = 3 * AXIS_BITS,
	localparam int IN_DATA_W  = ((6 * AXIS_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((6 * AXIS_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// index_i, index_j, index_k, linear_id
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// id_out, i_out, j_out, k_out
	output logic [OUT_DATA_W-1:0] m_tdata,
	// out_of_range
	output logic                  m_tuser
);
	import gic_pkg::*;

	localparam int A   = AXIS_BITS;
	localparam int NW  = A + 1;
	localparam int PW  = 2 * NW;
	localparam int W   = 3 * A + 1;
	localparam int S1W = ID_W + NW;
	localparam int S2W = ID_W + A;

	logic [A-1:0] cells_x, cells_y, cells_z;
	logic         adv;

	stage_flags_t    flags_f;
	logic [ID_W-1:0] lid_f;
	logic [PW-1:0]   plane_f;
	logic [ID_W-1:0] id_f;
	logic [NW-1:0]   nx_f;

	stage_flags_t   flags_p1 [A+1];
	logic [W-1:0]   rem_p1   [A+1];
	logic [W-1:0]   div_p1   [A+1];
	logic [A-1:0]   quo_p1   [A+1];
	logic [S1W-1:0] side_p1  [A+1];

	stage_flags_t   flags_p2 [A+1];
	logic [W-1:0]   rem_p2   [A+1];
	logic [W-1:0]   div_p2   [A+1];
	logic [A-1:0]   quo_p2   [A+1];
	logic [S2W-1:0] side_p2  [A+1];

	stage_flags_t        last;
	logic                fwd_ok, rev_ok;
	logic [ID_W-1:0]     res_id;
	logic [A-1:0]        res_i, res_j, res_k;
	logic [OUT_DATA_W-1:0] res_data;

	logic                  skid_vld_q;
	logic [OUT_DATA_W-1:0] skid_data_q;
	logic                  skid_bad_q;

	gic_apb_regs #(.AXIS_BITS(AXIS_BITS)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cells_x (cells_x),
		.cells_y (cells_y),
		.cells_z (cells_z)
	);

	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	gic_front #(.AXIS_BITS(AXIS_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.cells_x    (cells_x),
		.cells_y    (cells_y),
		.cells_z    (cells_z),
		.item_valid (s_tvalid),
		.command    (s_tuser),
		.index_i    (s_tdata[A-1:0]),
		.index_j    (s_tdata[2*A-1:A]),
		.index_k    (s_tdata[3*A-1:2*A]),
		.linear_id  (s_tdata[6*A-1:3*A]),
		.flags_s4   (flags_f),
		.lid_s4     (lid_f),
		.plane_s4   (plane_f),
		.id_s4      (id_f),
		.nx_s4      (nx_f)
	);

	// k = id / plane
	assign flags_p1[0] = flags_f;
	assign rem_p1[0]   = W'(lid_f);
	assign div_p1[0]   = W'(plane_f);
	assign quo_p1[0]   = '0;
	assign side_p1[0]  = {id_f, nx_f};

	for (genvar g = 0; g < A; g++) begin : g_div_k
		gic_div_step #(.AXIS_BITS(AXIS_BITS), .SHIFT(A - 1 - g), .SIDE_W(S1W)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.flags    (flags_p1[g]),
			.rem      (rem_p1[g]),
			.div      (div_p1[g]),
			.quo      (quo_p1[g]),
			.side     (side_p1[g]),
			.flags_s1 (flags_p1[g+1]),
			.rem_s1   (rem_p1[g+1]),
			.div_s1   (div_p1[g+1]),
			.quo_s1   (quo_p1[g+1]),
			.side_s1  (side_p1[g+1])
		);
	end

	// j = remainder / nx, i = what is left
	assign flags_p2[0] = flags_p1[A];
	assign rem_p2[0]   = rem_p1[A];
	assign div_p2[0]   = W'(side_p1[A][NW-1:0]);
	assign quo_p2[0]   = '0;
	assign side_p2[0]  = {side_p1[A][S1W-1 -: ID_W], quo_p1[A]};

	for (genvar g = 0; g < A; g++) begin : g_div_j
		gic_div_step #(.AXIS_BITS(AXIS_BITS), .SHIFT(A - 1 - g), .SIDE_W(S2W)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.flags    (flags_p2[g]),
			.rem      (rem_p2[g]),
			.div      (div_p2[g]),
			.quo      (quo_p2[g]),
			.side     (side_p2[g]),
			.flags_s1 (flags_p2[g+1]),
			.rem_s1   (rem_p2[g+1]),
			.div_s1   (div_p2[g+1]),
			.quo_s1   (quo_p2[g+1]),
			.side_s1  (side_p2[g+1])
		);
	end

	assign last   = flags_p2[A];
	assign fwd_ok = !last.rev && !last.bad;
	assign rev_ok = last.rev && !last.bad;
	assign res_id = fwd_ok ? side_p2[A][S2W-1 -: ID_W] : '0;
	assign res_i  = rev_ok ? rem_p2[A][A-1:0] : '0;
	assign res_j  = rev_ok ? quo_p2[A] : '0;
	assign res_k  = rev_ok ? side_p2[A][A-1:0] : '0;
	assign res_data = OUT_DATA_W'({res_k, res_j, res_i, res_id});

	// output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (last.valid && !m_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_data_q <= res_data;
			skid_bad_q  <= last.bad;
		end
	end

	assign m_tvalid = skid_vld_q || last.valid;
	assign m_tdata  = skid_vld_q ? skid_data_q : res_data;
	assign m_tuser  = skid_vld_q ? skid_bad_q : last.bad;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range result carries nonzero data");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid filled without an output stall");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid && last.rev && !last.bad |-> rem_p2[A] < div_p2[A])
		else $error("final remainder not below row size");

endmodule
